>>> src/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes for the Markov transition table.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned RND_W    = 16;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_BASE    = 3'd0,
    REQ_ADD_TRANS   = 3'd1,
    REQ_DRAW_BASE   = 3'd2,
    REQ_DRAW_PREFIX = 3'd3,
    REQ_DRAW_SUCC   = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CNT_CHK,
    S_MOD,
    S_FETCH,
    S_DRAW,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] successor;
    logic [RND_W-1:0] random_word;
  } req_item_t;

  typedef struct packed {
    logic [POS_W-1:0]    drawn_position;
    logic [STATUS_W-1:0] status;
    logic                position_is_base;
    logic                position_is_prefix;
  } rsp_item_t;

endpackage

>>> src/mtt_mod.sv
// ----------------------------------------------------------------------------
// mtt_mod
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mtt_mod #(
  parameter int unsigned DW = 16,
  parameter int unsigned NW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [NW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] div_q, div_d;
  logic [NW:0]   trial;
  logic [NW:0]   diff;

  // remainder stays below the divisor, so the trial is below twice of it
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        quo_d = {quo_q[DW-2:0], 1'b0};
        if (trial >= {1'b0, div_q}) begin
          rem_d = diff[NW-1:0];
        end else begin
          rem_d = trial[NW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < div_q))
    else $error("modulo result not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (div_q != '0))
    else $error("modulo started with zero divisor");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !start_i) |=> !busy_o)
    else $error("modulo unit still busy after done");

endmodule

>>> src/markov_transition_table.sv
// ----------------------------------------------------------------------------
// markov_transition_table
// Base list, prefix list and per-prefix successor lists held in synchronous
// memories; adds entries and draws list entries by random word modulo count.
// ----------------------------------------------------------------------------
// One item is worked at a time. Every item first scans the base and prefix
// lists, one entry of each per cycle, up to the larger of the base and prefix
// counts; a transition that extends a known prefix then reads the prefix's
// successor count. A draw adds the 16-step bit-serial modulo unit and the
// memory fetch; a successor draw first reads the prefix's successor count.
// A new item is taken as soon as the previous result sits in the output
// register. The count memory needs no clearing pass: a new prefix writes
// its count.
module markov_transition_table #(
  parameter int unsigned BASE_SLOTS      = 16,
  parameter int unsigned PREFIX_SLOTS    = 16,
  parameter int unsigned SUCCESSOR_SLOTS = 16,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtt_pkg::req_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mtt_pkg::rsp_item_t out_item_o
);

  import mtt_pkg::*;

  localparam int unsigned PW   = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
  localparam int unsigned BIW  = (BASE_SLOTS > 1) ? $clog2(BASE_SLOTS) : 1;
  localparam int unsigned PIW  = (PREFIX_SLOTS > 1) ? $clog2(PREFIX_SLOTS) : 1;
  localparam int unsigned SIW  = (SUCCESSOR_SLOTS > 1) ? $clog2(SUCCESSOR_SLOTS) : 1;
  localparam int unsigned BCW  = $clog2(BASE_SLOTS + 1);
  localparam int unsigned PCW  = $clog2(PREFIX_SLOTS + 1);
  localparam int unsigned SCW  = $clog2(SUCCESSOR_SLOTS + 1);
  localparam int unsigned MAXS = (BASE_SLOTS > PREFIX_SLOTS) ? BASE_SLOTS : PREFIX_SLOTS;
  localparam int unsigned XW   = $clog2(MAXS + 1);
  localparam int unsigned DNW0 = (BCW > PCW) ? BCW : PCW;
  localparam int unsigned DENW = (DNW0 > SCW) ? DNW0 : SCW;
  localparam int unsigned SDEP = 1 << (PIW + SIW);

  // storage
  logic [PW-1:0]  base_mem   [BASE_SLOTS];
  logic [PW-1:0]  prefix_mem [PREFIX_SLOTS];
  logic [SCW-1:0] cnt_mem    [PREFIX_SLOTS];
  logic [PW-1:0]  succ_mem   [SDEP];

  state_e         state_q, state_d;
  logic [BCW-1:0] base_cnt_q;
  logic [PCW-1:0] prefix_cnt_q;

  logic [REQ_W-1:0] req_q;
  logic [PW-1:0]    pos_q;
  logic [PW-1:0]    suc_q;
  logic [RND_W-1:0] rnd_q;

  logic [XW-1:0]  scan_idx_q;
  logic           rd_vld_q, rd_bok_q, rd_pok_q;
  logic [PIW-1:0] rd_idx_q;
  logic           hit_base_q, hit_pfx_q;
  logic [PIW-1:0] slot_q;

  logic [PW-1:0]  base_rdata_q, pfx_rdata_q, succ_rdata_q;
  logic [SCW-1:0] cnt_rdata_q;

  logic [PW-1:0]  res_drawn_q;
  status_e        res_status_q;

  logic           out_valid_q;
  rsp_item_t      out_item_q;

  // control
  logic            accept, issue, scan_done, out_free, out_load;
  logic [XW-1:0]   scan_lim;
  logic            base_room, pfx_room, succ_room;
  logic            base_we, pfx_we, cnt_we, succ_we;
  logic [PIW-1:0]  cnt_waddr;
  logic [SCW-1:0]  cnt_wdata;
  logic [PIW+SIW-1:0] succ_waddr;
  logic [BIW-1:0]  base_raddr;
  logic [PIW-1:0]  pfx_raddr;
  logic            set_full, set_nf;
  logic            mod_start, mod_busy, mod_done;
  logic [DENW-1:0] mod_div, mod_rem;

  assign scan_lim  = (XW'(base_cnt_q) > XW'(prefix_cnt_q)) ? XW'(base_cnt_q)
                                                            : XW'(prefix_cnt_q);
  assign issue     = (state_q == S_SCAN) && (scan_idx_q < scan_lim);
  assign scan_done = !issue && !rd_vld_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = (state_q == S_IDLE) && in_valid_i;
  assign base_room = base_cnt_q < BCW'(BASE_SLOTS);
  assign pfx_room  = prefix_cnt_q < PCW'(PREFIX_SLOTS);
  assign succ_room = cnt_rdata_q < SCW'(SUCCESSOR_SLOTS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (req_q)
          REQ_ADD_TRANS, REQ_DRAW_SUCC: state_d = hit_pfx_q ? S_CNT_CHK : S_DONE;
          REQ_DRAW_BASE:   state_d = (base_cnt_q != '0) ? S_MOD : S_DONE;
          REQ_DRAW_PREFIX: state_d = (prefix_cnt_q != '0) ? S_MOD : S_DONE;
          default:         state_d = S_DONE;
        endcase
      end
      S_CNT_CHK: begin
        state_d = (req_q == REQ_DRAW_SUCC && cnt_rdata_q != '0) ? S_MOD : S_DONE;
      end
      S_MOD: begin
        if (mod_done) state_d = S_FETCH;
      end
      S_FETCH: state_d = S_DRAW;
      S_DRAW:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    base_we    = 1'b0;
    pfx_we     = 1'b0;
    cnt_we     = 1'b0;
    succ_we    = 1'b0;
    cnt_waddr  = slot_q;
    cnt_wdata  = cnt_rdata_q + 1'b1;
    succ_waddr = {slot_q, cnt_rdata_q[SIW-1:0]};
    set_full   = 1'b0;
    set_nf     = 1'b0;
    mod_start  = 1'b0;
    mod_div    = DENW'(base_cnt_q);
    out_load   = 1'b0;
    unique case (state_q)
      S_DECIDE: begin
        unique case (req_q)
          REQ_ADD_BASE: begin
            base_we  = base_room;
            set_full = !base_room;
          end
          REQ_ADD_TRANS: begin
            if (!hit_pfx_q) begin
              // new prefix: its list starts with this successor
              pfx_we     = pfx_room;
              cnt_we     = pfx_room;
              succ_we    = pfx_room;
              set_full   = !pfx_room;
              cnt_waddr  = prefix_cnt_q[PIW-1:0];
              cnt_wdata  = SCW'(1);
              succ_waddr = {prefix_cnt_q[PIW-1:0], SIW'(0)};
            end
          end
          REQ_DRAW_BASE: begin
            mod_start = base_cnt_q != '0;
            set_nf    = base_cnt_q == '0;
          end
          REQ_DRAW_PREFIX: begin
            mod_div   = DENW'(prefix_cnt_q);
            mod_start = prefix_cnt_q != '0;
            set_nf    = prefix_cnt_q == '0;
          end
          REQ_DRAW_SUCC: begin
            set_nf = !hit_pfx_q;
          end
          default: ;
        endcase
      end
      S_CNT_CHK: begin
        if (req_q == REQ_ADD_TRANS) begin
          cnt_we   = succ_room;
          succ_we  = succ_room;
          set_full = !succ_room;
        end else begin
          mod_div   = DENW'(cnt_rdata_q);
          mod_start = cnt_rdata_q != '0;
          set_nf    = cnt_rdata_q == '0;
        end
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign base_raddr = (state_q == S_FETCH) ? mod_rem[BIW-1:0] : scan_idx_q[BIW-1:0];
  assign pfx_raddr  = (state_q == S_FETCH) ? mod_rem[PIW-1:0] : scan_idx_q[PIW-1:0];

  // memories; items are worked one at a time, so a read never races a write
  always_ff @(posedge clk_i) begin
    if (base_we) base_mem[base_cnt_q[BIW-1:0]] <= pos_q;
    base_rdata_q <= base_mem[base_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pfx_we) prefix_mem[prefix_cnt_q[PIW-1:0]] <= pos_q;
    pfx_rdata_q <= prefix_mem[pfx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata_q <= cnt_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (succ_we) succ_mem[succ_waddr] <= suc_q;
    succ_rdata_q <= succ_mem[{slot_q, mod_rem[SIW-1:0]}];
  end

  mtt_mod #(
    .DW (RND_W),
    .NW (DENW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (mod_div),
    .busy_o     (mod_busy),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      base_cnt_q   <= '0;
      prefix_cnt_q <= '0;
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      hit_base_q   <= 1'b0;
      hit_pfx_q    <= 1'b0;
      res_status_q <= STATUS_OK;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (accept) begin
        scan_idx_q   <= '0;
        hit_base_q   <= 1'b0;
        hit_pfx_q    <= 1'b0;
        res_status_q <= STATUS_OK;
      end
      if (issue) scan_idx_q <= scan_idx_q + 1'b1;
      if (rd_vld_q) begin
        if (rd_bok_q && base_rdata_q == pos_q) hit_base_q <= 1'b1;
        if (rd_pok_q && pfx_rdata_q == pos_q)  hit_pfx_q  <= 1'b1;
      end
      if (base_we) begin
        base_cnt_q <= base_cnt_q + 1'b1;
        hit_base_q <= 1'b1;
      end
      if (pfx_we) begin
        prefix_cnt_q <= prefix_cnt_q + 1'b1;
        hit_pfx_q    <= 1'b1;
      end
      if (set_full) res_status_q <= STATUS_FULL;
      if (set_nf)   res_status_q <= STATUS_NOT_FOUND;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q       <= in_item_i.req_type;
      pos_q       <= in_item_i.position[PW-1:0];
      suc_q       <= in_item_i.successor[PW-1:0];
      rnd_q       <= in_item_i.random_word;
      res_drawn_q <= '0;
    end
    rd_bok_q <= scan_idx_q < XW'(base_cnt_q);
    rd_pok_q <= scan_idx_q < XW'(prefix_cnt_q);
    rd_idx_q <= scan_idx_q[PIW-1:0];
    // first matching prefix slot wins
    if (rd_vld_q && rd_pok_q && pfx_rdata_q == pos_q && !hit_pfx_q) slot_q <= rd_idx_q;
    if (state_q == S_DRAW) begin
      unique case (req_q)
        REQ_DRAW_BASE:   res_drawn_q <= base_rdata_q;
        REQ_DRAW_PREFIX: res_drawn_q <= pfx_rdata_q;
        default:         res_drawn_q <= succ_rdata_q;
      endcase
    end
    if (out_load) begin
      out_item_q.drawn_position     <= POS_W'(res_drawn_q);
      out_item_q.status             <= res_status_q;
      out_item_q.position_is_base   <= hit_base_q;
      out_item_q.position_is_prefix <= hit_pfx_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_idle_mod_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mod_busy)
    else $error("modulo unit busy while idle");

  a_base_we_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_we |-> (base_cnt_q < BCW'(BASE_SLOTS)))
    else $error("base write past the end of the list");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an item not yet taken");

  a_pfx_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DECIDE) |=> $stable(prefix_cnt_q))
    else $error("prefix count changed outside decide");

endmodule
